FILE: design/mbe_pkg.sv
// ----------------------------------------------------------------------------
// mbe_pkg
// Shared types and constants for the escape-time pixel evaluator.
// ----------------------------------------------------------------------------
`default_nettype none

package mbe_pkg;

  localparam int CoordWidthDef = 32;
  localparam int CountWidthDef = 16;
  localparam int IntBits       = 6;
  localparam int PosWidth      = 12;
  localparam int SizeWidth     = 13;
  localparam int IterWidth     = 16;
  localparam int RadiusWidth   = 4;
  localparam int ZoomWidth     = 21;
  localparam int OffsetWidth   = 32;
  localparam int CfgDataWidth  = 32;
  localparam int CfgIdxWidth   = 3;

  localparam logic [CfgIdxWidth-1:0] REG_WIDTH    = 3'd0;
  localparam logic [CfgIdxWidth-1:0] REG_HEIGHT   = 3'd1;
  localparam logic [CfgIdxWidth-1:0] REG_MAX_ITER = 3'd2;
  localparam logic [CfgIdxWidth-1:0] REG_RADIUS   = 3'd3;
  localparam logic [CfgIdxWidth-1:0] REG_ZOOM     = 3'd4;
  localparam logic [CfgIdxWidth-1:0] REG_REAL_OFF = 3'd5;
  localparam logic [CfgIdxWidth-1:0] REG_IMAG_OFF = 3'd6;

  typedef struct packed {
    logic [SizeWidth-1:0]          width;
    logic [SizeWidth-1:0]          height;
    logic [IterWidth-1:0]          max_iter;
    logic [RadiusWidth-1:0]        radius;
    logic [ZoomWidth-1:0]          zoom;
    logic signed [OffsetWidth-1:0] real_off;
    logic signed [OffsetWidth-1:0] imag_off;
  } cfg_t;

endpackage

`default_nettype wire

FILE: design/mbe_front.sv
// ----------------------------------------------------------------------------
// mbe_front
// Maps a pixel position to a point c with a shared serial divider.
// ----------------------------------------------------------------------------
`default_nettype none

module mbe_front #(
  parameter int COORD_WIDTH = mbe_pkg::CoordWidthDef
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  mbe_pkg::cfg_t                     cfg_i,
  input  wire                               start_i,
  input  wire  [mbe_pkg::PosWidth-1:0]      row_i,
  input  wire  [mbe_pkg::PosWidth-1:0]      column_i,
  output logic                              busy_o,
  output logic                              push_o,
  output logic [2*COORD_WIDTH-1:0]          push_data_o,
  input  wire                               full_i
);
  import mbe_pkg::*;

  localparam int Frac = COORD_WIDTH - IntBits;
  localparam int CenW = PosWidth + 3;
  localparam int MagW = CenW + Frac;
  localparam int DivW = SizeWidth + ZoomWidth;
  localparam int SumW = ((MagW > OffsetWidth) ? MagW : OffsetWidth) + 2;
  localparam int CntW = $clog2(MagW + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SETUP = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_FIN   = 3'd3;
  localparam logic [2:0] S_PUSH  = 3'd4;

  localparam logic [SumW-1:0] Hi = {{(SumW-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}};
  localparam logic [SumW-1:0] Lo = ~Hi;

  logic [2:0]             state_q, state_d;
  logic                   phase_q, phase_d;
  logic [PosWidth-1:0]    row_q, row_d, col_q, col_d;
  logic [MagW-1:0]        mag_q, mag_d;
  logic [DivW-1:0]        rem_q, rem_d, div_q, div_d;
  logic                   neg_q, neg_d;
  logic [OffsetWidth-1:0] off_q, off_d;
  logic [CntW-1:0]        cnt_q, cnt_d;
  logic [COORD_WIDTH-1:0] cre_q, cre_d, cim_q, cim_d;

  logic [PosWidth-1:0]    pos;
  logic [SizeWidth-1:0]   sz;
  logic [ZoomWidth-1:0]   zm;
  logic [CenW-1:0]        centred, cmag;
  logic [DivW:0]          trial;
  logic                   ge;
  logic [SumW-1:0]        qext, qs, offext, sum;
  logic [COORD_WIDTH-1:0] res;

  always_comb begin
    pos     = phase_q ? row_q : col_q;
    sz      = phase_q ? cfg_i.height : cfg_i.width;
    if (sz == '0) begin
      sz = SizeWidth'(1);
    end
    zm      = (cfg_i.zoom == '0) ? ZoomWidth'(1) : cfg_i.zoom;
    centred = {2'b00, pos, 1'b0} - {2'b00, sz};
    cmag    = centred[CenW-1] ? (~centred + 1'b1) : centred;

    trial   = {rem_q, mag_q[MagW-1]};
    ge      = (trial >= {1'b0, div_q});

    qext    = {{(SumW-MagW){1'b0}}, mag_q};
    qs      = neg_q ? (~qext + 1'b1) : qext;
    offext  = {{(SumW-OffsetWidth){off_q[OffsetWidth-1]}}, off_q};
    sum     = qs + offext;
    if ($signed(sum) > $signed(Hi)) begin
      res = Hi[COORD_WIDTH-1:0];
    end else if ($signed(sum) < $signed(Lo)) begin
      res = Lo[COORD_WIDTH-1:0];
    end else begin
      res = sum[COORD_WIDTH-1:0];
    end
  end

  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    row_d   = row_q;
    col_d   = col_q;
    mag_d   = mag_q;
    rem_d   = rem_q;
    div_d   = div_q;
    neg_d   = neg_q;
    off_d   = off_q;
    cnt_d   = cnt_q;
    cre_d   = cre_q;
    cim_d   = cim_q;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          row_d   = row_i;
          col_d   = column_i;
          phase_d = 1'b0;
          state_d = S_SETUP;
        end
      end
      S_SETUP: begin
        mag_d   = {cmag, {Frac{1'b0}}};
        rem_d   = '0;
        div_d   = DivW'(sz) * DivW'(zm);
        neg_d   = centred[CenW-1];
        off_d   = phase_q ? cfg_i.imag_off : cfg_i.real_off;
        cnt_d   = CntW'(MagW);
        state_d = S_DIV;
      end
      S_DIV: begin
        rem_d = ge ? DivW'(trial - {1'b0, div_q}) : DivW'(trial);
        mag_d = {mag_q[MagW-2:0], ge};
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (!phase_q) begin
          cre_d   = res;
          phase_d = 1'b1;
          state_d = S_SETUP;
        end else begin
          cim_d   = res;
          state_d = S_PUSH;
        end
      end
      S_PUSH: begin
        if (!full_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      phase_q <= 1'b0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    row_q <= row_d;
    col_q <= col_d;
    mag_q <= mag_d;
    rem_q <= rem_d;
    div_q <= div_d;
    neg_q <= neg_d;
    off_q <= off_d;
    cnt_q <= cnt_d;
    cre_q <= cre_d;
    cim_q <= cim_d;
  end

  assign busy_o      = (state_q != S_IDLE);
  assign push_o      = (state_q == S_PUSH) && !full_i;
  assign push_data_o = {cre_q, cim_q};

endmodule

`default_nettype wire

FILE: design/mbe_queue.sv
// ----------------------------------------------------------------------------
// mbe_queue
// Two-entry queue of mapped points between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module mbe_queue #(
  parameter int WIDTH = 2 * mbe_pkg::CoordWidthDef
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              push_i,
  input  wire  [WIDTH-1:0] data_i,
  output logic             full_o,
  input  wire              pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);
  logic [WIDTH-1:0] mem_q [2];
  logic             wptr_q, rptr_q;
  logic [1:0]       cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wptr_q <= ~wptr_q;
      end
      if (pop_i) begin
        rptr_q <= ~rptr_q;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= data_i;
    end
  end

  assign data_o  = mem_q[rptr_q];
  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);

endmodule

`default_nettype wire

FILE: design/mbe_back.sv
// ----------------------------------------------------------------------------
// mbe_back
// Iterates z = z*z + c with an escape test, a multiply step then a test-and-update step.
// ----------------------------------------------------------------------------
`default_nettype none

module mbe_back #(
  parameter int COORD_WIDTH = mbe_pkg::CoordWidthDef,
  parameter int COUNT_WIDTH = mbe_pkg::CountWidthDef
) (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  mbe_pkg::cfg_t             cfg_i,
  input  wire                       empty_i,
  input  wire  [2*COORD_WIDTH-1:0]  data_i,
  output logic                      pop_o,
  output logic                      done_o,
  output logic [COUNT_WIDTH-1:0]    iteration_count_o
);
  import mbe_pkg::*;

  localparam int Frac = COORD_WIDTH - IntBits;
  localparam int PW   = 2 * COORD_WIDTH;
  localparam int NW   = PW + 1;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL  = 2'd1;
  localparam logic [1:0] S_UPD  = 2'd2;

  localparam logic [NW-1:0] Hi = {{(NW-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}};
  localparam logic [NW-1:0] Lo = ~Hi;

  logic [1:0]                    state_q, state_d;
  logic signed [COORD_WIDTH-1:0] cre_q, cre_d, cim_q, cim_d;
  logic signed [COORD_WIDTH-1:0] zre_q, zre_d, zim_q, zim_d;
  logic signed [PW-1:0]          sqre_q, sqre_d, sqim_q, sqim_d, cross_q, cross_d;
  logic [IterWidth-1:0]          cnt_q, cnt_d;
  logic                          done_q, done_d;
  logic [COUNT_WIDTH-1:0]        res_q, res_d;

  logic [PW-1:0]                 mag2, limit;
  logic [7:0]                    rr;
  logic signed [NW-1:0]          diff, nre, nim;
  logic                          esc;

  function automatic logic [COORD_WIDTH-1:0] sat(input logic [NW-1:0] v);
    logic [COORD_WIDTH-1:0] r;
    if ($signed(v) > $signed(Hi)) begin
      r = Hi[COORD_WIDTH-1:0];
    end else if ($signed(v) < $signed(Lo)) begin
      r = Lo[COORD_WIDTH-1:0];
    end else begin
      r = v[COORD_WIDTH-1:0];
    end
    return r;
  endfunction

  always_comb begin
    mag2  = sqre_q + sqim_q;
    rr    = 8'(cfg_i.radius) * 8'(cfg_i.radius);
    limit = PW'(rr) << (2 * Frac);
    esc   = !(mag2 < limit) || (cnt_q >= cfg_i.max_iter);
    diff  = {sqre_q[PW-1], sqre_q} - {sqim_q[PW-1], sqim_q};
    nre   = (diff >>> Frac)
            + $signed({{(NW-COORD_WIDTH){cre_q[COORD_WIDTH-1]}}, cre_q});
    nim   = ($signed({cross_q[PW-1], cross_q}) >>> (Frac - 1))
            + $signed({{(NW-COORD_WIDTH){cim_q[COORD_WIDTH-1]}}, cim_q});
  end

  always_comb begin
    state_d = state_q;
    cre_d   = cre_q;
    cim_d   = cim_q;
    zre_d   = zre_q;
    zim_d   = zim_q;
    sqre_d  = sqre_q;
    sqim_d  = sqim_q;
    cross_d = cross_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    res_d   = res_q;
    pop_o   = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (!empty_i) begin
          pop_o   = 1'b1;
          cre_d   = data_i[PW-1:COORD_WIDTH];
          cim_d   = data_i[COORD_WIDTH-1:0];
          zre_d   = data_i[PW-1:COORD_WIDTH];
          zim_d   = data_i[COORD_WIDTH-1:0];
          cnt_d   = '0;
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        sqre_d  = zre_q * zre_q;
        sqim_d  = zim_q * zim_q;
        cross_d = zre_q * zim_q;
        state_d = S_UPD;
      end
      S_UPD: begin
        if (esc) begin
          done_d  = 1'b1;
          res_d   = COUNT_WIDTH'(cnt_q);
          state_d = S_IDLE;
        end else begin
          zre_d   = sat(nre);
          zim_d   = sat(nim);
          cnt_d   = cnt_q + 1'b1;
          state_d = S_MUL;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cre_q   <= cre_d;
    cim_q   <= cim_d;
    zre_q   <= zre_d;
    zim_q   <= zim_d;
    sqre_q  <= sqre_d;
    sqim_q  <= sqim_d;
    cross_q <= cross_d;
    cnt_q   <= cnt_d;
    res_q   <= res_d;
  end

  assign done_o            = done_q;
  assign iteration_count_o = res_q;

endmodule

`default_nettype wire

FILE: design/mandelbrot_escape_time_core.sv
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_core
// Escape-time evaluator: pixel position in, iteration count out.
//
//   channel  signals                                  direction
//   command  start_i, busy_o, row_i, column_i        in
//   result   done_o, iteration_count_o               out
//   config   cfg_we_i, cfg_index_i, cfg_data_i       in
//
// front: maps each pixel with the serial divider, real part then imaginary part
// back: per iteration a multiply step, then a test and update step; each pixel
// runs until escape or max_iter in the back; front and back overlap
// through a two-entry queue, busy_o is high while the front is occupied
// results appear on done_o for one cycle; the receiver cannot stall
// reset restores the default register values and empties the queue
// ----------------------------------------------------------------------------
`default_nettype none

module mandelbrot_escape_time_core #(
  parameter int COORD_WIDTH = mbe_pkg::CoordWidthDef,
  parameter int COUNT_WIDTH = mbe_pkg::CountWidthDef
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               start_i,
  output logic                              busy_o,
  input  wire  [mbe_pkg::PosWidth-1:0]      row_i,
  input  wire  [mbe_pkg::PosWidth-1:0]      column_i,
  output logic                              done_o,
  output logic [COUNT_WIDTH-1:0]            iteration_count_o,
  input  wire                               cfg_we_i,
  input  wire  [mbe_pkg::CfgIdxWidth-1:0]   cfg_index_i,
  input  wire  [mbe_pkg::CfgDataWidth-1:0]  cfg_data_i
);
  import mbe_pkg::*;

  cfg_t                   cfg_q;
  logic                   push, full, pop, empty;
  logic [2*COORD_WIDTH-1:0] qin, qout;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.width    <= SizeWidth'(640);
      cfg_q.height   <= SizeWidth'(480);
      cfg_q.max_iter <= IterWidth'(256);
      cfg_q.radius   <= RadiusWidth'(2);
      cfg_q.zoom     <= ZoomWidth'(1);
      cfg_q.real_off <= '0;
      cfg_q.imag_off <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_WIDTH:    cfg_q.width    <= cfg_data_i[SizeWidth-1:0];
        REG_HEIGHT:   cfg_q.height   <= cfg_data_i[SizeWidth-1:0];
        REG_MAX_ITER: cfg_q.max_iter <= cfg_data_i[IterWidth-1:0];
        REG_RADIUS:   cfg_q.radius   <= cfg_data_i[RadiusWidth-1:0];
        REG_ZOOM:     cfg_q.zoom     <= cfg_data_i[ZoomWidth-1:0];
        REG_REAL_OFF: cfg_q.real_off <= cfg_data_i[OffsetWidth-1:0];
        REG_IMAG_OFF: cfg_q.imag_off <= cfg_data_i[OffsetWidth-1:0];
        default: ;
      endcase
    end
  end

  mbe_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .start_i     (start_i),
    .row_i       (row_i),
    .column_i    (column_i),
    .busy_o      (busy_o),
    .push_o      (push),
    .push_data_o (qin),
    .full_i      (full)
  );

  mbe_queue #(.WIDTH(2 * COORD_WIDTH)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (qin),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (qout),
    .empty_o (empty)
  );

  mbe_back #(.COORD_WIDTH(COORD_WIDTH), .COUNT_WIDTH(COUNT_WIDTH)) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_i             (cfg_q),
    .empty_i           (empty),
    .data_i            (qout),
    .pop_o             (pop),
    .done_o            (done_o),
    .iteration_count_o (iteration_count_o)
  );

endmodule

`default_nettype wire
